// ===== design/lsti_pkg.sv =====
// ----------------------------------------------------------------------------
// lsti_pkg
// Shared types and constants of the L-system turtle interpreter.
// ----------------------------------------------------------------------------
package lsti_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ACTION_W    = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int STEP_W      = 31;
    localparam int TRIG_W      = 18;
    localparam int S_TDATA_W   = 192;
    localparam int M_TDATA_W   = 96;
    localparam int M_TUSER_W   = 3;

    typedef logic signed [31:0] q16_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    // input symbol codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_START  = 4'd0,
        ACT_DRAW   = 4'd1,
        ACT_MOVE   = 4'd2,
        ACT_PLUS   = 4'd3,
        ACT_MINUS  = 4'd4,
        ACT_AMP    = 4'd5,
        ACT_CARET  = 4'd6,
        ACT_BSLASH = 4'd7,
        ACT_SLASH  = 4'd8,
        ACT_BAR    = 4'd9,
        ACT_LBRACK = 4'd10,
        ACT_RBRACK = 4'd11
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_LENGTH = 3'd0,
        REG_COS_X       = 3'd1,
        REG_SIN_X       = 3'd2,
        REG_COS_Y       = 3'd3,
        REG_SIN_Y       = 3'd4,
        REG_COS_Z       = 3'd5,
        REG_SIN_Z       = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_MOVE,
        OP_ROTATE,
        OP_REVERSE,
        OP_PUSH,
        OP_POP,
        OP_UNKNOWN
    } op_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef enum logic [1:0] {
        ST_POINT     = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNKNOWN   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MOVE,
        BK_ROTATE,
        BK_POP
    } bk_state_t;

    typedef struct packed {
        op_t              op;
        logic             draw;
        axis_t            axis;
        logic             neg;
        q16_t [2:0]       pos;
        q16_t [2:0]       dir;
    } cmd_t;

    typedef struct packed {
        logic [STEP_W-1:0] step_length;
        trig_t             cos_x;
        trig_t             sin_x;
        trig_t             cos_y;
        trig_t             sin_y;
        trig_t             cos_z;
        trig_t             sin_z;
    } cfg_t;

    typedef struct packed {
        q16_t    x;
        q16_t    y;
        q16_t    z;
        logic    draw;
        status_t status;
        logic    last;
    } result_t;

endpackage

// ===== design/lsystem_turtle_interpreter.sv =====
// ----------------------------------------------------------------------------
// lsystem_turtle_interpreter
// 3D turtle interpreter for L-system symbols in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One symbol per input word (action in s_tuser). The front decodes and queues
// up to two words; s_tready falls only while both entries are held. The back
// finishes start, |, [ and errors in its idle state; F/f (multiply stage,
// then round and add), rotations (product stage, then sum, round, saturate)
// and ] (registered read of the stack memory) take a second state. F/f emit
// two words (old and new point, tlast on the second); stack overflow,
// underflow and unknown symbols emit one word with a status code. Results
// wait in a 4-word queue; the back starts a command only with room for two
// results. Stack holds 64 saved states in an on-chip memory.
// ----------------------------------------------------------------------------
module lsystem_turtle_interpreter (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lsti_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsti_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_x, start_y, start_z, start_dir_x, start_dir_y, start_dir_z
    input  logic [lsti_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [lsti_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // point_x, point_y, point_z
    output logic [lsti_pkg::M_TDATA_W-1:0]  m_tdata,
    // draw, status[1:0]
    output logic [lsti_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import lsti_pkg::*;

    cfg_t  cfg_reg;
    logic  cmd_valid, cmd_ready;
    cmd_t  cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_length <= STEP_W'(65536);
            cfg_reg.cos_x       <= TRIG_W'(65536);
            cfg_reg.sin_x       <= '0;
            cfg_reg.cos_y       <= TRIG_W'(65536);
            cfg_reg.sin_y       <= '0;
            cfg_reg.cos_z       <= TRIG_W'(65536);
            cfg_reg.sin_z       <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STEP_LENGTH: cfg_reg.step_length <= cfg_wdata[STEP_W-1:0];
                REG_COS_X:       cfg_reg.cos_x       <= cfg_wdata[TRIG_W-1:0];
                REG_SIN_X:       cfg_reg.sin_x       <= cfg_wdata[TRIG_W-1:0];
                REG_COS_Y:       cfg_reg.cos_y       <= cfg_wdata[TRIG_W-1:0];
                REG_SIN_Y:       cfg_reg.sin_y       <= cfg_wdata[TRIG_W-1:0];
                REG_COS_Z:       cfg_reg.cos_z       <= cfg_wdata[TRIG_W-1:0];
                REG_SIN_Z:       cfg_reg.sin_z       <= cfg_wdata[TRIG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lsti_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    lsti_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== design/lsti_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// lsti_cmd_queue
// Two-entry command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module lsti_cmd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lsti_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output lsti_pkg::cmd_t out_cmd
);
    import lsti_pkg::*;

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    cmd_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== design/lsti_front.sv =====
// ----------------------------------------------------------------------------
// lsti_front
// Accepts input words, decodes the symbol into a command and queues it.
// ----------------------------------------------------------------------------
module lsti_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x, start_y, start_z, start_dir_x, start_dir_y, start_dir_z
    input  logic [lsti_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic [lsti_pkg::ACTION_W-1:0]  s_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_ready,
    output lsti_pkg::cmd_t                 cmd
);
    import lsti_pkg::*;

    cmd_t dec;

    always_comb begin
        dec        = '0;
        dec.op     = OP_UNKNOWN;
        dec.draw   = 1'b0;
        dec.axis   = AXIS_X;
        dec.neg    = 1'b0;
        dec.pos[0] = s_tdata[31:0];
        dec.pos[1] = s_tdata[63:32];
        dec.pos[2] = s_tdata[95:64];
        dec.dir[0] = s_tdata[127:96];
        dec.dir[1] = s_tdata[159:128];
        dec.dir[2] = s_tdata[191:160];
        case (s_tuser)
            ACT_START: begin
                dec.op = OP_START;
            end
            ACT_DRAW: begin
                dec.op   = OP_MOVE;
                dec.draw = 1'b1;
            end
            ACT_MOVE: begin
                dec.op = OP_MOVE;
            end
            ACT_PLUS, ACT_MINUS: begin
                dec.op   = OP_ROTATE;
                dec.axis = AXIS_X;
                dec.neg  = (s_tuser == ACT_MINUS);
            end
            ACT_AMP, ACT_CARET: begin
                dec.op   = OP_ROTATE;
                dec.axis = AXIS_Y;
                dec.neg  = (s_tuser == ACT_CARET);
            end
            ACT_BSLASH, ACT_SLASH: begin
                dec.op   = OP_ROTATE;
                dec.axis = AXIS_Z;
                dec.neg  = (s_tuser == ACT_SLASH);
            end
            ACT_BAR: begin
                dec.op = OP_REVERSE;
            end
            ACT_LBRACK: begin
                dec.op = OP_PUSH;
            end
            ACT_RBRACK: begin
                dec.op = OP_POP;
            end
            default: begin
                dec.op = OP_UNKNOWN;
            end
        endcase
    end

    lsti_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (dec),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_cmd   (cmd)
    );

endmodule

// ===== design/lsti_back.sv =====
// ----------------------------------------------------------------------------
// lsti_back
// Executes commands: turtle state, multiply stages, push/pop stack memory
// and the result queue toward the master port.
// ----------------------------------------------------------------------------
module lsti_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lsti_pkg::cfg_t                 cfg,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  lsti_pkg::cmd_t                 cmd,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // point_x, point_y, point_z
    output logic [lsti_pkg::M_TDATA_W-1:0] m_tdata,
    // draw, status[1:0]
    output logic [lsti_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                           m_tlast
);
    import lsti_pkg::*;

    localparam int OUTQ_DEPTH = 4;
    localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
    localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);
    localparam int ROW_W      = 6 * 32;

    function automatic q16_t sat32(input logic signed [34:0] v);
        q16_t r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    bk_state_t         state_reg, state_next;
    q16_t [2:0]        pos_reg, pos_next;
    q16_t [2:0]        dir_reg, dir_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic              draw_reg, draw_next;
    axis_t             axis_reg, axis_next;
    logic              neg_reg, neg_next;

    // multiply stage
    logic signed [31:0] step_s;
    logic signed [63:0] mv_prod_reg [3];
    q16_t               rot_a_op, rot_b_op;
    trig_t              rot_c_op, rot_s_op;
    logic signed [49:0] ca_reg, sb_reg, sa_reg, cb_reg;

    // second stage
    logic signed [63:0] mv_rnd [3];
    q16_t [2:0]         mv_pos;
    logic signed [50:0] sum_a, sum_b;
    q16_t               rot_a, rot_b;

    // stack memory
    logic [ROW_W-1:0]   stack_mem [STACK_DEPTH];
    logic [ROW_W-1:0]   stk_rd_reg;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [SP_W-1:0]    sp_dec;

    // result queue
    result_t            outq_reg [OUTQ_DEPTH];
    logic [OQ_AW-1:0]   oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [OQ_CW-1:0]   oq_cnt_reg, oq_cnt_next;
    logic               oq_room, res_push, res_pop;
    result_t            res_data, oq_head;
    logic               fire;

    assign step_s  = {1'b0, cfg.step_length};
    assign sp_dec  = sp_reg - SP_W'(1);
    assign wr_addr = sp_reg[ADDR_W-1:0];
    assign rd_addr = sp_dec[ADDR_W-1:0];
    assign oq_room = (oq_cnt_reg <= OQ_CW'(OUTQ_DEPTH - 2));

    always_comb begin
        rot_a_op = dir_reg[1];
        rot_b_op = dir_reg[2];
        rot_c_op = cfg.cos_x;
        rot_s_op = cfg.sin_x;
        case (cmd.axis)
            AXIS_X: begin
                rot_a_op = dir_reg[1];
                rot_b_op = dir_reg[2];
                rot_c_op = cfg.cos_x;
                rot_s_op = cfg.sin_x;
            end
            AXIS_Y: begin
                rot_a_op = dir_reg[2];
                rot_b_op = dir_reg[0];
                rot_c_op = cfg.cos_y;
                rot_s_op = cfg.sin_y;
            end
            AXIS_Z: begin
                rot_a_op = dir_reg[0];
                rot_b_op = dir_reg[1];
                rot_c_op = cfg.cos_z;
                rot_s_op = cfg.sin_z;
            end
            default: begin
                rot_a_op = dir_reg[1];
                rot_b_op = dir_reg[2];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            mv_prod_reg[i] <= dir_reg[i] * step_s;
        end
        ca_reg <= rot_a_op * rot_c_op;
        sb_reg <= rot_b_op * rot_s_op;
        sa_reg <= rot_a_op * rot_s_op;
        cb_reg <= rot_b_op * rot_c_op;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mv_rnd[i] = mv_prod_reg[i] + 64'sd32768;
            mv_pos[i] = pos_reg[i] + q16_t'(mv_rnd[i][47:16]);
        end
        sum_a = neg_reg ? (ca_reg + sb_reg) : (ca_reg - sb_reg);
        sum_b = neg_reg ? (cb_reg - sa_reg) : (cb_reg + sa_reg);
        rot_a = sat32(35'((sum_a + 51'sd32768) >>> 16));
        rot_b = sat32(35'((sum_b + 51'sd32768) >>> 16));
    end

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        dir_next   = dir_reg;
        sp_next    = sp_reg;
        draw_next  = draw_reg;
        axis_next  = axis_reg;
        neg_next   = neg_reg;
        res_push   = 1'b0;
        res_data   = '0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        cmd_ready  = (state_reg == BK_IDLE) && oq_room;
        fire       = cmd_valid && cmd_ready;
        case (state_reg)
            BK_IDLE: begin
                if (fire) begin
                    draw_next = cmd.draw;
                    axis_next = cmd.axis;
                    neg_next  = cmd.neg;
                    case (cmd.op)
                        OP_START: begin
                            pos_next = cmd.pos;
                            dir_next = cmd.dir;
                            sp_next  = '0;
                        end
                        OP_MOVE: begin
                            res_push        = 1'b1;
                            res_data.x      = pos_reg[0];
                            res_data.y      = pos_reg[1];
                            res_data.z      = pos_reg[2];
                            res_data.draw   = cmd.draw;
                            res_data.status = ST_POINT;
                            res_data.last   = 1'b0;
                            state_next      = BK_MOVE;
                        end
                        OP_ROTATE: begin
                            state_next = BK_ROTATE;
                        end
                        OP_REVERSE: begin
                            for (int i = 0; i < 3; i++) begin
                                dir_next[i] = (dir_reg[i] == 32'sh80000000) ?
                                              32'sh7FFFFFFF : -dir_reg[i];
                            end
                        end
                        OP_PUSH: begin
                            if (sp_reg >= SP_W'(STACK_DEPTH)) begin
                                res_push        = 1'b1;
                                res_data.status = ST_OVERFLOW;
                                res_data.last   = 1'b1;
                            end else begin
                                mem_we  = 1'b1;
                                sp_next = sp_reg + SP_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (sp_reg == '0) begin
                                res_push        = 1'b1;
                                res_data.status = ST_UNDERFLOW;
                                res_data.last   = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                sp_next    = sp_dec;
                                state_next = BK_POP;
                            end
                        end
                        default: begin
                            res_push        = 1'b1;
                            res_data.status = ST_UNKNOWN;
                            res_data.last   = 1'b1;
                        end
                    endcase
                end
            end
            BK_MOVE: begin
                pos_next        = mv_pos;
                res_push        = 1'b1;
                res_data.x      = mv_pos[0];
                res_data.y      = mv_pos[1];
                res_data.z      = mv_pos[2];
                res_data.draw   = draw_reg;
                res_data.status = ST_POINT;
                res_data.last   = 1'b1;
                state_next      = BK_IDLE;
            end
            BK_ROTATE: begin
                case (axis_reg)
                    AXIS_X: begin
                        dir_next[1] = rot_a;
                        dir_next[2] = rot_b;
                    end
                    AXIS_Y: begin
                        dir_next[2] = rot_a;
                        dir_next[0] = rot_b;
                    end
                    AXIS_Z: begin
                        dir_next[0] = rot_a;
                        dir_next[1] = rot_b;
                    end
                    default: begin
                        dir_next = dir_reg;
                    end
                endcase
                state_next = BK_IDLE;
            end
            BK_POP: begin
                {pos_next, dir_next} = stk_rd_reg;
                state_next           = BK_IDLE;
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            pos_reg   <= '0;
            dir_reg   <= '0;
            sp_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            dir_reg   <= dir_next;
            sp_reg    <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        draw_reg <= draw_next;
        axis_reg <= axis_next;
        neg_reg  <= neg_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_addr] <= {pos_reg, dir_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            stk_rd_reg <= stack_mem[rd_addr];
        end
    end

    // result queue
    assign oq_head  = outq_reg[oq_rd_ptr_reg];
    assign m_tvalid = (oq_cnt_reg != '0);
    assign m_tdata  = {oq_head.z, oq_head.y, oq_head.x};
    assign m_tuser  = {oq_head.status, oq_head.draw};
    assign m_tlast  = oq_head.last;
    assign res_pop  = m_tvalid && m_tready;

    always_comb begin
        oq_cnt_next = oq_cnt_reg;
        if (res_push && !res_pop) begin
            oq_cnt_next = oq_cnt_reg + OQ_CW'(1);
        end else if (res_pop && !res_push) begin
            oq_cnt_next = oq_cnt_reg - OQ_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end else begin
            if (res_push) begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + OQ_AW'(1);
            end
            if (res_pop) begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + OQ_AW'(1);
            end
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            outq_reg[oq_wr_ptr_reg] <= res_data;
        end
    end

endmodule

// ===== tb/tb_lsystem_turtle_interpreter.sv =====
// ----------------------------------------------------------------------------
// tb_lsystem_turtle_interpreter
// Self-checking bench for the Q16.16 L-system turtle interpreter.
// A driver streams symbol words from a queue, back to back or in random bursts. A predictor
// follows the turtle state, the push/pop stack and the turn registers, and a
// monitor checks every result word field by field against the oldest
// prediction, while the result side stalls on patterns of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lsystem_turtle_interpreter;

    import lsti_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [CFG_IDX_W-1:0] REG_NONE      = 3'd7;
    localparam logic [ACTION_W-1:0]  FIRST_UNKNOWN = ACT_RBRACK + 4'd1;
    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;
    localparam q16_t Q_ONE = 32'sd65536;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [S_TDATA_W-1:0] data;
    } sym_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [ACTION_W-1:0]   s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    lsystem_turtle_interpreter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sym_word_t symbol_words [$];
    result_t   want_results [$];
    int        error_count = 0;
    int        gen_depth   = 0;

    // predicted turtle and register copies
    logic [STEP_W-1:0] cfg_step;
    trig_t cfg_cos_x, cfg_sin_x, cfg_cos_y, cfg_sin_y, cfg_cos_z, cfg_sin_z;
    q16_t  turtle_pos [3];
    q16_t  turtle_dir [3];
    q16_t  saved_pos [STACK_DEPTH][3];
    q16_t  saved_dir [STACK_DEPTH][3];
    int    turtle_sp;

    int tx_mode = 0;
    int rx_mode = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_tick = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    bit in_fire = 1'b0;

    function automatic longint round_q16(input longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic q16_t sat32(input longint v);
        if (v > 64'sd2147483647)
            return Q_MAX;
        if (v < -64'sd2147483648)
            return Q_MIN;
        return q16_t'(v);
    endfunction

    task automatic turn(inout q16_t a, inout q16_t b, input longint c, input longint s);
        longint na, nb;
        na = round_q16(c * longint'(a) - s * longint'(b));
        nb = round_q16(s * longint'(a) + c * longint'(b));
        a = sat32(na);
        b = sat32(nb);
    endtask

    task automatic add_result(input q16_t x, input q16_t y, input q16_t z,
                              input logic draw, input status_t st, input logic last);
        result_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        r.draw = draw;
        r.status = st;
        r.last = last;
        want_results.insert(want_results.size(), r);
    endtask

    task automatic interpret_symbol(input logic [ACTION_W-1:0] act,
                                    input logic [S_TDATA_W-1:0] data);
        q16_t   nxt [3];
        longint d;
        case (act)
            ACT_START: begin
                for (int i = 0; i < 3; i++) begin
                    turtle_pos[i] = data[32*i +: 32];
                    turtle_dir[i] = data[96 + 32*i +: 32];
                end
                turtle_sp = 0;
            end
            ACT_DRAW, ACT_MOVE: begin
                for (int i = 0; i < 3; i++) begin
                    d = round_q16(longint'(turtle_dir[i]) * longint'({1'b0, cfg_step}));
                    nxt[i] = turtle_pos[i] + q16_t'(d[31:0]);
                end
                add_result(turtle_pos[0], turtle_pos[1], turtle_pos[2],
                           act == ACT_DRAW, ST_POINT, 1'b0);
                add_result(nxt[0], nxt[1], nxt[2], act == ACT_DRAW, ST_POINT, 1'b1);
                turtle_pos = nxt;
            end
            ACT_PLUS:   turn(turtle_dir[1], turtle_dir[2], cfg_cos_x, cfg_sin_x);
            ACT_MINUS:  turn(turtle_dir[1], turtle_dir[2], cfg_cos_x, -longint'(cfg_sin_x));
            ACT_AMP:    turn(turtle_dir[2], turtle_dir[0], cfg_cos_y, cfg_sin_y);
            ACT_CARET:  turn(turtle_dir[2], turtle_dir[0], cfg_cos_y, -longint'(cfg_sin_y));
            ACT_BSLASH: turn(turtle_dir[0], turtle_dir[1], cfg_cos_z, cfg_sin_z);
            ACT_SLASH:  turn(turtle_dir[0], turtle_dir[1], cfg_cos_z, -longint'(cfg_sin_z));
            ACT_BAR: begin
                for (int i = 0; i < 3; i++)
                    turtle_dir[i] = sat32(-longint'(turtle_dir[i]));
            end
            ACT_LBRACK: begin
                if (turtle_sp >= STACK_DEPTH) begin
                    add_result('0, '0, '0, 1'b0, ST_OVERFLOW, 1'b1);
                end else begin
                    saved_pos[turtle_sp] = turtle_pos;
                    saved_dir[turtle_sp] = turtle_dir;
                    turtle_sp++;
                end
            end
            ACT_RBRACK: begin
                if (turtle_sp == 0) begin
                    add_result('0, '0, '0, 1'b0, ST_UNDERFLOW, 1'b1);
                end else begin
                    turtle_sp--;
                    turtle_pos = saved_pos[turtle_sp];
                    turtle_dir = saved_dir[turtle_sp];
                end
            end
            default: add_result('0, '0, '0, 1'b0, ST_UNKNOWN, 1'b1);
        endcase
    endtask

    function automatic bit field_ok(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // check results, then predict the word taken at this edge
    always @(posedge aclk) begin
        result_t want;
        bit      ok;
        if (!aresetn) begin
            in_fire = 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (want_results.size() == 0) begin
                    $display("%0t: unexpected result word, actual %0h %0h %0b", $time,
                             m_tdata, m_tuser, m_tlast);
                    error_count++;
                end else begin
                    want = want_results.pop_front();
                    ok = field_ok("point_x", want.x, m_tdata[31:0])
                       & field_ok("point_y", want.y, m_tdata[63:32])
                       & field_ok("point_z", want.z, m_tdata[95:64])
                       & field_ok("draw", 32'(want.draw), 32'(m_tuser[0]))
                       & field_ok("status", 32'(want.status), 32'(m_tuser[2:1]))
                       & field_ok("last", 32'(want.last), 32'(m_tlast));
                    if (!ok)
                        error_count++;
                end
            end
            in_fire = s_tvalid && s_tready;
            if (in_fire)
                interpret_symbol(s_tuser, s_tdata);
        end
    end

    always @(negedge aclk) begin
        sym_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (symbol_words.size() != 0) begin
                w = symbol_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= w.action;
                s_tdata  <= w.data;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    case (tx_mode)
                        0: begin
                            burst_left = 1000;
                            gap_left = 0;
                        end
                        1: begin
                            burst_left = $urandom_range(1, 16);
                            gap_left = $urandom_range(0, 3);
                        end
                        default: begin
                            burst_left = $urandom_range(1, 6);
                            gap_left = $urandom_range(0, 25);
                        end
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_tick++;
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (rx_tick % 5) < 3;
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STEP_LENGTH: cfg_step  = val[STEP_W-1:0];
            REG_COS_X:       cfg_cos_x = trig_t'(val[TRIG_W-1:0]);
            REG_SIN_X:       cfg_sin_x = trig_t'(val[TRIG_W-1:0]);
            REG_COS_Y:       cfg_cos_y = trig_t'(val[TRIG_W-1:0]);
            REG_SIN_Y:       cfg_sin_y = trig_t'(val[TRIG_W-1:0]);
            REG_COS_Z:       cfg_cos_z = trig_t'(val[TRIG_W-1:0]);
            REG_SIN_Z:       cfg_sin_z = trig_t'(val[TRIG_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (symbol_words.size() != 0 || s_tvalid || want_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic pick_turn(output int c, output int s);
        case ($urandom_range(0, 5))
            0: begin c = 65536;  s = 0;     end
            1: begin c = 0;      s = 65536; end
            2: begin c = 46341;  s = 46341; end
            3: begin c = 59047;  s = 28440; end
            4: begin c = -65536; s = -65536; end
            default: begin
                c = int'($urandom_range(0, 131072)) - 65536;
                s = int'($urandom_range(0, 131072)) - 65536;
            end
        endcase
        if ($urandom_range(0, 1))
            s = -s;
    endtask

    task automatic random_config();
        int c, s;
        case ($urandom_range(0, 5))
            0: write_reg(REG_STEP_LENGTH, '0);
            1: write_reg(REG_STEP_LENGTH, 31'd1);
            2: write_reg(REG_STEP_LENGTH, 31'(Q_ONE));
            3: write_reg(REG_STEP_LENGTH, 31'h7FFF_FFFF);
            4: write_reg(REG_STEP_LENGTH, 31'($urandom_range(0, 4 * 65536)));
            default: write_reg(REG_STEP_LENGTH, 31'($urandom));
        endcase
        pick_turn(c, s);
        write_reg(REG_COS_X, 31'(c));
        write_reg(REG_SIN_X, 31'(s));
        pick_turn(c, s);
        write_reg(REG_COS_Y, 31'(c));
        write_reg(REG_SIN_Y, 31'(s));
        pick_turn(c, s);
        write_reg(REG_COS_Z, 31'(c));
        write_reg(REG_SIN_Z, 31'(s));
        end_writes();
    endtask

    function automatic q16_t rand_pos();
        case ($urandom_range(0, 3))
            0, 1: return int'($urandom_range(0, 400 * 65536)) - 200 * 65536;
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    function automatic q16_t rand_dir();
        case ($urandom_range(0, 4))
            0, 1, 2: return int'($urandom_range(0, 2 * 65536)) - 65536;
            3: return $urandom;
            default: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        endcase
    endfunction

    task automatic push_word(input logic [ACTION_W-1:0] act, input logic [S_TDATA_W-1:0] data);
        sym_word_t w;
        w.action = act;
        w.data = data;
        symbol_words.insert(symbol_words.size(), w);
        if (act == ACT_START)
            gen_depth = 0;
        else if (act == ACT_LBRACK && gen_depth < STACK_DEPTH)
            gen_depth++;
        else if (act == ACT_RBRACK && gen_depth > 0)
            gen_depth--;
    endtask

    task automatic send_start(input q16_t x, input q16_t y, input q16_t z,
                              input q16_t dx, input q16_t dy, input q16_t dz);
        push_word(ACT_START, {dz, dy, dx, z, y, x});
    endtask

    task automatic send_symbol(input logic [ACTION_W-1:0] act);
        if (act == ACT_START)
            send_start(rand_pos(), rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir());
        else
            push_word(act, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    endtask

    // mostly well-formed strings, with stray and unknown symbols mixed in
    task automatic gen_string(input int count, input int push_pct, input int noise_pct);
        logic [ACTION_W-1:0] a;
        int n, r;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < noise_pct) begin
                case ($urandom_range(0, 2))
                    0: a = FIRST_UNKNOWN + 4'($urandom_range(0, 3));
                    1: a = ACT_RBRACK;
                    default: a = 4'($urandom);
                endcase
            end else if (r < 3) begin
                a = ACT_START;
            end else if (r < 30) begin
                a = ACT_DRAW;
            end else if (r < 40) begin
                a = ACT_MOVE;
            end else if (r < 70) begin
                a = ACT_PLUS + 4'($urandom_range(0, 5));
            end else if (r < 75) begin
                a = ACT_BAR;
            end else if (r < 75 + push_pct) begin
                a = ACT_LBRACK;
            end else begin
                a = (gen_depth > 0) ? ACT_RBRACK : ACT_DRAW;
            end
            send_symbol(a);
        end
    endtask

    initial begin
        int n;
        cfg_step = 31'(Q_ONE);
        cfg_cos_x = 18'sd65536;
        cfg_sin_x = '0;
        cfg_cos_y = 18'sd65536;
        cfg_sin_y = '0;
        cfg_cos_z = 18'sd65536;
        cfg_sin_z = '0;
        for (n = 0; n < 3; n++) begin
            turtle_pos[n] = '0;
            turtle_dir[n] = '0;
        end
        turtle_sp = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset registers: empty-stack pop, zero state, wrap, saturation
        send_symbol(ACT_RBRACK);
        send_symbol(ACT_DRAW);
        send_symbol(FIRST_UNKNOWN);
        send_start(Q_MAX, Q_MIN, '0, Q_MAX, Q_MIN, -1);
        send_symbol(ACT_DRAW);
        send_symbol(ACT_MOVE);
        send_symbol(ACT_BAR);
        send_symbol(ACT_LBRACK);
        send_symbol(ACT_DRAW);
        send_symbol(ACT_RBRACK);
        send_symbol(ACT_MOVE);
        for (n = 0; n < 6; n++)
            send_symbol(ACT_PLUS + 4'(n));
        send_symbol(4'hF);
        wait_idle();

        // extreme registers
        write_reg(REG_STEP_LENGTH, 31'h7FFF_FFFF);
        write_reg(REG_COS_X, 31'(-65536));
        write_reg(REG_SIN_X, 31'(65536));
        write_reg(REG_COS_Y, 31'(65536));
        write_reg(REG_SIN_Y, 31'(-65536));
        write_reg(REG_COS_Z, '0);
        write_reg(REG_SIN_Z, 31'(65536));
        write_reg(REG_NONE, 31'($urandom));
        end_writes();
        send_start(32'sd12345, -32'sd7, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        for (n = 0; n < 6; n++)
            send_symbol(ACT_PLUS + 4'(n));
        send_symbol(ACT_DRAW);
        send_symbol(ACT_BAR);
        send_symbol(ACT_MOVE);
        send_start('0, '0, '0, Q_ONE, '0, -Q_ONE);
        send_symbol(ACT_DRAW);
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_NONE, 31'($urandom));
            end_writes();
            tx_mode = phase % 3;
            rx_mode = phase % 4;
            if (phase == 2) begin
                tx_mode = 0;
                hold_req++;
                for (n = 0; n < 30; n++)
                    send_symbol($urandom_range(0, 3) ? ACT_DRAW : ACT_MOVE);
            end
            if (phase == 5) begin
                send_symbol(ACT_START);
                for (n = 0; n < STACK_DEPTH + 4; n++) begin
                    send_symbol(ACT_LBRACK);
                    send_symbol($urandom_range(0, 1) ? ACT_DRAW : ACT_PLUS + 4'($urandom_range(0, 5)));
                end
                for (n = 0; n < STACK_DEPTH + 2; n++) begin
                    send_symbol(ACT_RBRACK);
                    if ($urandom_range(0, 1))
                        send_symbol(ACT_MOVE);
                end
            end
            gen_string(120, (phase == 7) ? 20 : 10, (phase == 4) ? 20 : 4);
            wait_idle();
        end

        wait_idle();
        if (error_count == 0 && want_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
